[rtl/core/alux_pkg.sv]
// Package for the ambient light lux calculator: payload types, constants
// and the code-to-count and correction lookup tables. No dependencies.
`default_nettype none
package alux_pkg;

    localparam int CodeW  = 7;
    localparam int CountW = 12;
    localparam int LuxW   = 12;
    localparam int QW     = 8;
    localparam int FactW  = 7;
    localparam int DivSteps = 8;
    localparam logic [LuxW-1:0] MaxLuxReset = 12'd1846;

    typedef struct packed {
        logic [CodeW-1:0] channel0_code;
        logic [CodeW-1:0] channel1_code;
    } in_item_t;

    typedef struct packed {
        logic [LuxW-1:0] lux;
        logic            invalid;
    } out_item_t;

    function automatic logic [CountW-1:0] code_to_count(input logic [CodeW-1:0] c);
        logic [CountW-1:0] r;
        r = '0;
        if (c < 7'd16)       r = {5'd0, c};
        else if (c < 7'd32)  r = CountW'(16 + 2 * (int'(c) - 16));
        else if (c < 7'd48)  r = CountW'(49 + 4 * (int'(c) - 32));
        else if (c < 7'd64)  r = CountW'(115 + 8 * (int'(c) - 48));
        else if (c < 7'd80)  r = CountW'(247 + 16 * (int'(c) - 64));
        else if (c < 7'd96)  r = CountW'(511 + 32 * (int'(c) - 80));
        else if (c < 7'd112) r = CountW'(1039 + 64 * (int'(c) - 96));
        else                 r = CountW'(2095 + 128 * (int'(c) - 112));
        return r;
    endfunction

    localparam logic [FactW-1:0] CorrTab [0:128] = '{
        7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
        7'd100, 7'd100, 7'd100, 7'd100, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd98, 7'd98, 7'd98, 7'd98, 7'd98, 7'd98,
        7'd98, 7'd97, 7'd97, 7'd97, 7'd97, 7'd97, 7'd96, 7'd96, 7'd96, 7'd96, 7'd95,
        7'd95, 7'd95, 7'd94, 7'd94, 7'd93, 7'd93, 7'd93, 7'd92, 7'd92, 7'd91, 7'd91, 7'd90,
        7'd89, 7'd89, 7'd88, 7'd87, 7'd87, 7'd86, 7'd85, 7'd84, 7'd83, 7'd82, 7'd81,
        7'd80, 7'd79, 7'd78, 7'd77, 7'd75, 7'd74, 7'd73, 7'd71, 7'd69, 7'd68, 7'd66, 7'd64,
        7'd62, 7'd60, 7'd58, 7'd56, 7'd54, 7'd52, 7'd49, 7'd47, 7'd44, 7'd42, 7'd41,
        7'd40, 7'd40, 7'd39, 7'd39, 7'd38, 7'd38, 7'd37, 7'd37, 7'd37, 7'd36, 7'd36, 7'd36,
        7'd35, 7'd35, 7'd35, 7'd35, 7'd34, 7'd34, 7'd34, 7'd34, 7'd33, 7'd33, 7'd33,
        7'd33, 7'd32, 7'd32, 7'd32, 7'd32, 7'd32, 7'd31, 7'd31, 7'd31, 7'd31, 7'd31, 7'd30,
        7'd30, 7'd30, 7'd30, 7'd30
    };

endpackage
`default_nettype wire

[rtl/core/ambient_light_lux_calc_unit.sv]
// Top level of the ambient light lux calculator: a pipeline of table
// lookup, restoring ratio division, correction multiply and clamp.
// Depends on alux_pkg.
//
//   channel   direction  handshake     payload
//   in        request in valid/stall   alux_pkg::in_item_t
//   out       result out valid/stall   alux_pkg::out_item_t
//   cfg       write in   valid/ready   max_lux, 12 bits
//
// One request can enter every cycle while the output is not stalled. The
// ratio divider resolves one quotient bit per stage over eight stages.
// Reset clears all stage valid bits and restores max_lux to 1846.
// A stall on the output freezes the whole pipeline at once; the input
// stall is the output stall of the last stage while that stage holds data.
`default_nettype none
module ambient_light_lux_calc_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire alux_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output alux_pkg::out_item_t       out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [11:0]          cfg_data
);
    import alux_pkg::*;

    // Stage count: 1 lookup, DivSteps divide, 1 multiply, 1 scale/clamp,
    // and the output register.
    localparam int NStg = DivSteps + 4;

    typedef struct packed {
        logic [CountW-1:0] c0;
        logic [CountW-1:0] c1;
        logic [CountW:0]   rem;   // partial remainder of c1*128
        logic [QW-1:0]     q;
        logic              bad;
    } div_t;

    logic [LuxW-1:0] max_lux_reg;
    logic            adv;

    // Whole-pipeline enable: move whenever the output is not held.
    assign adv       = !(out_valid && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_lux_reg <= MaxLuxReset;
        else if (cfg_valid && cfg_ready)
            max_lux_reg <= cfg_data;
    end

    logic [NStg-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NStg-2:0], in_valid};
    end
    assign out_valid = vld_reg[NStg-1];

    // Stage 0: count lookup and validity.
    div_t d_reg [0:DivSteps];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0].c0  <= code_to_count(in_data.channel0_code);
            d_reg[0].c1  <= code_to_count(in_data.channel1_code);
            d_reg[0].rem <= '0;
            d_reg[0].q   <= '0;
            d_reg[0].bad <= (code_to_count(in_data.channel0_code) == '0) ||
                (code_to_count(in_data.channel1_code) >
                 code_to_count(in_data.channel0_code));
        end
    end

    // Divide stages: dividend is c1 followed by seven zero bits; remainder
    // starts as c1 and each later stage brings in one zero bit (8 quotient bits).
    for (genvar s = 0; s < DivSteps; s++)
    begin : g_div
        logic [CountW+1:0] trial;
        logic [CountW:0]   base;
        always_comb
        begin
            base  = (s == 0) ? {1'b0, d_reg[s].c1} : d_reg[s].rem;
            trial = (s == 0) ? {1'b0, base} : {base, 1'b0};
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[s+1].c0  <= d_reg[s].c0;
                d_reg[s+1].c1  <= d_reg[s].c1;
                d_reg[s+1].bad <= d_reg[s].bad;
                if (trial >= {2'b0, d_reg[s].c0})
                begin
                    d_reg[s+1].rem <= (CountW+1)'(trial - {2'b0, d_reg[s].c0});
                    d_reg[s+1].q   <= {d_reg[s].q[QW-2:0], 1'b1};
                end
                else
                begin
                    d_reg[s+1].rem <= trial[CountW:0];
                    d_reg[s+1].q   <= {d_reg[s].q[QW-2:0], 1'b0};
                end
            end
        end
    end

    // Multiply stage: difference times correction factor.
    logic [CountW+FactW-1:0] prod_reg;
    logic                    mbad_reg;
    logic [QW-1:0]           qc;
    logic [CountW-1:0]       diff;
    assign qc   = (d_reg[DivSteps].q > 8'd128) ? 8'd128 : d_reg[DivSteps].q;
    assign diff = d_reg[DivSteps].c0 - d_reg[DivSteps].c1;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= {{FactW{1'b0}}, diff} * {{CountW{1'b0}}, CorrTab[qc]};
            mbad_reg <= d_reg[DivSteps].bad;
        end
    end

    // Scale and clamp stage.
    logic [CountW+FactW-9:0] scaled;
    out_item_t               res_reg;
    assign scaled = prod_reg[CountW+FactW-1:8];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.invalid <= mbad_reg;
            if (mbad_reg)
                res_reg.lux <= '0;
            else if ({1'b0, scaled} > max_lux_reg)
                res_reg.lux <= max_lux_reg;
            else
                res_reg.lux <= {1'b0, scaled};
        end
    end

    // Output register.
    out_item_t out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= res_reg;
    end
    assign out_data = out_reg;

endmodule
`default_nettype wire

[rtl/core/alux_checker.sv]
// Port-level checker for the lux calculator, bound to the top level.
// Depends on alux_pkg.
`default_nettype none
module alux_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire alux_pkg::out_item_t out_data
);
    import alux_pkg::*;

    // An invalid result always reports zero lux.
    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.invalid |-> out_data.lux == '0)
        else $error("invalid result with nonzero lux");

    // The input is held back only while a result is held.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // A held result does not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("held result changed");

endmodule

bind ambient_light_lux_calc_unit alux_checker u_alux_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
